// ===== sv/hvd_pkg.sv =====
package hvd_pkg;

    // field widths
    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DIST_W = 25;

    localparam int ANGLE_FRAC_BITS_DEF = 20;

    // fixed point format
    localparam int Q            = 30;
    localparam int CW           = 34;
    localparam int CORDIC_ITERS = 30;

    typedef logic signed [CW-1:0] t_cw;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam t_cw         CORDIC_GAIN = 34'sd652032874;
    localparam logic [23:0] DIST_SCALE  = 24'd12742000;
    localparam logic [24:0] DIST_MAX    = 25'd20015086;

    localparam t_cw ANGLE_TAB [10] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149
    };

    // atan(2^-i) in q30
    function automatic t_cw step_angle(input int unsigned i);
        t_cw a;
        if (i < 10) begin
            a = ANGLE_TAB[i];
        end else begin
            a = t_cw'(64'(1) << (Q - i));
        end
        return a;
    endfunction

endpackage

// ===== sv/hvd_if.sv =====
interface hvd_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [hvd_pkg::LAT_W-1:0] lat_a;
    logic signed [hvd_pkg::LON_W-1:0] lon_a;
    logic signed [hvd_pkg::LAT_W-1:0] lat_b;
    logic signed [hvd_pkg::LON_W-1:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hvd_out_if;
    logic                        valid;
    logic                        ready;
    logic [hvd_pkg::DIST_W-1:0]  distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

// ===== sv/hvd_cordic.sv =====
module hvd_cordic #(
    parameter bit VECT = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  hvd_pkg::t_cw   i_x,
    input  hvd_pkg::t_cw   i_y,
    input  hvd_pkg::t_cw   i_z,
    output hvd_pkg::t_cw   o_x,
    output hvd_pkg::t_cw   o_y,
    output hvd_pkg::t_cw   o_z
);

    localparam int N = hvd_pkg::CORDIC_ITERS;

    hvd_pkg::t_cw r_x [N];
    hvd_pkg::t_cw r_y [N];
    hvd_pkg::t_cw r_z [N];

    for (genvar i = 0; i < N; i++) begin : g_it
        hvd_pkg::t_cw x, y, z, n_x, n_y, n_z;
        logic         pos;

        if (i == 0) begin : g_first
            assign x = i_x;
            assign y = i_y;
            assign z = i_z;
        end else begin : g_next
            assign x = r_x[i-1];
            assign y = r_y[i-1];
            assign z = r_z[i-1];
        end

        // vectoring drives y to zero, rotation drives z to zero
        assign pos = VECT ? !(y > 0) : (z >= 0);

        always_comb begin
            if (pos) begin
                n_x = x - (y >>> i);
                n_y = y + (x >>> i);
                n_z = z - hvd_pkg::step_angle(i);
            end else begin
                n_x = x + (y >>> i);
                n_y = y - (x >>> i);
                n_z = z + hvd_pkg::step_angle(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
    end

    assign o_x = r_x[N-1];
    assign o_y = r_y[N-1];
    assign o_z = r_z[N-1];

endmodule

// ===== sv/haversine_distance_top.sv =====
// haversine great-circle distance, fixed point, fully pipelined
// throughput: one request per cycle; the whole pipe holds while the result waits
// stage count is set by the two cordic chains and the 31-step square roots,
// one step per register stage
// reset (synchronous, active low) clears only the valid bits; no state is kept
module haversine_distance_top #(
    parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hvd_in_if.sink     i_req,
    hvd_out_if.source  o_res
);

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int SQ_N  = 31;
    localparam int ITERS = hvd_pkg::CORDIC_ITERS;
    localparam int LAT   = 8 + ITERS + 4 + SQ_N + ITERS + 2;
    localparam int NEG_D = 2 + ITERS;

    // full turn, half turn and quarter turn in input angle units
    localparam logic [63:0] TURN  = 64'(360) << F;
    localparam logic [63:0] HALF  = 64'(180) << F;
    localparam logic [63:0] QTR   = 64'(90) << F;
    // multiple of a turn that makes every difference non-negative
    localparam logic [63:0] OFF   = TURN * ((64'(1) << 30) / TURN + 64'(1));
    // reciprocal of a turn, scaled by 2^36, for the wrap quotient estimate
    localparam logic [63:0] RECIP = (64'(1) << 36) / TURN;
    localparam logic [61:0] ONE_Q = 62'(1) << hvd_pkg::Q;

    // a full turn is 45 << (F + 3) and a half turn 45 << (F + 2), so the
    // radian conversion is an exact floor division by 45 and a shift
    localparam logic [63:0] ODD    = 64'(45);
    localparam logic [63:0] PI_DIV = 64'(hvd_pkg::PI_Q30) / ODD;
    localparam logic [63:0] PI_REM = 64'(hvd_pkg::PI_Q30) - PI_DIV * ODD;
    // ceil(PI_REM * 2^32 / 45), exact floor for any magnitude below 2^30
    localparam logic [63:0] REM_M  = ((PI_REM << 32) + ODD - 64'(1)) / ODD;

    // pipeline advance: everything moves together unless the output stalls
    logic                 w_adv;
    logic [LAT-1:0]       r_vld;

    assign w_adv       = !r_vld[LAT-1] || o_res.ready;
    assign i_req.ready = w_adv;
    assign o_res.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // lanes: 0 latitude difference, 1 longitude difference, 2 lat_a, 3 lat_b
    logic signed [29:0] r_d   [4];
    logic [35:0]        r_wx  [4];
    logic [35:0]        r_wx2 [4];
    logic [16:0]        r_wq  [4];
    logic [35:0]        r_wr  [4];
    logic signed [35:0] r_ws  [4];
    logic [31:0]        r_mag [4];
    logic [63:0]        r_pa  [4];
    logic [63:0]        r_pb  [4];
    logic [30:0]        r_q   [4];
    logic [1:0]         r_neg;
    logic [NEG_D-1:0][1:0] r_negp;
    hvd_pkg::t_cw       w_sn  [4];
    hvd_pkg::t_cw       w_cs  [4];

    // input register: differences and latitudes, sign extended
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d[0] <= 30'(i_req.lat_b) - 30'(i_req.lat_a);
            r_d[1] <= 30'(i_req.lon_b) - 30'(i_req.lon_a);
            r_d[2] <= 30'(i_req.lat_a);
            r_d[3] <= 30'(i_req.lat_b);
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        // half angles divide by a full turn, whole latitudes by a half turn
        localparam int SH = (l < 2) ? F + 3 : F + 2;
        logic [35:0] w_fix;
        logic [31:0] w_abs;

        assign w_fix = (r_wr[l] >= 36'(TURN)) ? r_wr[l] - 36'(TURN) : r_wr[l];
        assign w_abs = 32'((r_ws[l] < 0) ? -r_ws[l] : r_ws[l]);

        // wrap into [-half turn, half turn): offset, estimate quotient, fix once
        // then mag * pi / 45 as mag * (pi div 45) + floor(mag * (pi mod 45) / 45)
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_wx[l]  <= 36'(64'(r_d[l]) + HALF + OFF);
                r_wq[l]  <= 17'((53'(r_wx[l]) * 53'(RECIP)) >> 36);
                r_wx2[l] <= r_wx[l];
                r_wr[l]  <= r_wx2[l] - 36'(53'(r_wq[l]) * 53'(TURN));
                r_ws[l]  <= signed'(w_fix - 36'(HALF));
                r_pa[l]  <= 64'(r_mag[l]) * PI_DIV;
                r_pb[l]  <= 64'(r_mag[l]) * REM_M;
                r_q[l]   <= 31'((r_pa[l] + (r_pb[l] >> 32)) >> SH);
            end
        end

        if (l < 2) begin : g_half
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_mag[l] <= w_abs;
                end
            end
        end else begin : g_fold
            // latitude past a quarter turn: cos(x) = -cos(half turn - x)
            logic w_over;
            assign w_over = 64'(w_abs) > QTR;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_mag[l]   <= w_over ? 32'(HALF - 64'(w_abs)) : w_abs;
                    r_neg[l-2] <= w_over;
                end
            end
        end

        // sine and cosine of the angle in radians q30
        hvd_cordic #(.VECT(1'b0)) u_rot (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_x   (hvd_pkg::CORDIC_GAIN),
            .i_y   ('0),
            .i_z   (hvd_pkg::t_cw'(r_q[l])),
            .o_x   (w_cs[l]),
            .o_y   (w_sn[l]),
            .o_z   ()
        );
    end

    // fold flags ride along with the conversion and cordic stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_negp <= {r_negp[NEG_D-2:0], r_neg};
        end
    end

    // haversine combination
    logic signed [67:0] w_p_u, w_p_v, w_p_c, w_p_cv;
    hvd_pkg::t_cw       w_ca, w_cb;
    hvd_pkg::t_cw       r_u2, r_v2, r_ca, r_cb;
    hvd_pkg::t_cw       r_u2b, r_v2b, r_c, r_u2c, r_cv;
    logic signed [34:0] w_hs;
    logic [30:0]        r_h;

    assign w_ca   = r_negp[NEG_D-1][0] ? -w_cs[2] : w_cs[2];
    assign w_cb   = r_negp[NEG_D-1][1] ? -w_cs[3] : w_cs[3];
    assign w_p_u  = w_sn[0] * w_sn[0];
    assign w_p_v  = w_sn[1] * w_sn[1];
    assign w_p_c  = r_ca * r_cb;
    assign w_p_cv = r_c * r_v2b;
    assign w_hs   = 35'(r_u2c) + 35'(r_cv);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u2  <= hvd_pkg::t_cw'(w_p_u >>> hvd_pkg::Q);
            r_v2  <= hvd_pkg::t_cw'(w_p_v >>> hvd_pkg::Q);
            r_ca  <= w_ca;
            r_cb  <= w_cb;
            r_c   <= hvd_pkg::t_cw'(w_p_c >>> hvd_pkg::Q);
            r_u2b <= r_u2;
            r_v2b <= r_v2;
            r_cv  <= hvd_pkg::t_cw'(w_p_cv >>> hvd_pkg::Q);
            r_u2c <= r_u2b;
            // clamp h to the unit interval
            if (w_hs < 0) begin
                r_h <= '0;
            end else if (w_hs > 35'(ONE_Q)) begin
                r_h <= 31'(ONE_Q);
            end else begin
                r_h <= w_hs[30:0];
            end
        end
    end

    // bitwise integer square roots of h and 1 - h, in q30
    logic [61:0] r_sn [2][SQ_N];
    logic [61:0] r_sr [2][SQ_N];

    for (genvar m = 0; m < 2; m++) begin : g_sq
        for (genvar j = 0; j < SQ_N; j++) begin : g_st
            localparam logic [61:0] BIT = 62'(1) << (2 * (SQ_N - 1 - j));
            logic [61:0] w_n, w_r, w_t;

            if (j == 0) begin : g_first
                if (m == 0) begin : g_s
                    assign w_n = 62'(r_h) << hvd_pkg::Q;
                end else begin : g_c
                    assign w_n = (ONE_Q - 62'(r_h)) << hvd_pkg::Q;
                end
                assign w_r = '0;
            end else begin : g_next
                assign w_n = r_sn[m][j-1];
                assign w_r = r_sr[m][j-1];
            end
            assign w_t = w_r + BIT;

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (w_n >= w_t) begin
                        r_sn[m][j] <= w_n - w_t;
                        r_sr[m][j] <= (w_r >> 1) + BIT;
                    end else begin
                        r_sn[m][j] <= w_n;
                        r_sr[m][j] <= w_r >> 1;
                    end
                end
            end
        end
    end

    // central angle as atan2(sqrt(h), sqrt(1 - h))
    hvd_pkg::t_cw w_th;

    hvd_cordic #(.VECT(1'b1)) u_vec (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (hvd_pkg::t_cw'(r_sr[1][SQ_N-1][30:0])),
        .i_y   (hvd_pkg::t_cw'(r_sr[0][SQ_N-1][30:0])),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (w_th)
    );

    // clamp to [0, pi/2], scale by twice the radius in meters
    logic [30:0] w_theta;
    logic [54:0] r_prod;
    logic [24:0] r_dist;

    always_comb begin
        if (w_th < 0) begin
            w_theta = '0;
        end else if (w_th > hvd_pkg::t_cw'(hvd_pkg::HALF_PI_Q30)) begin
            w_theta = hvd_pkg::HALF_PI_Q30;
        end else begin
            w_theta = w_th[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= 55'(w_theta) * 55'(hvd_pkg::DIST_SCALE);
            r_dist <= r_prod[54:30];
        end
    end

    assign o_res.distance_m = r_dist;

    // a stalled pipe keeps its valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // an accepted request enters the first stage
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request lost");

    // result never exceeds half the circumference
    a_dist_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.distance_m <= hvd_pkg::DIST_MAX))
        else $error("distance out of range");

    // clamped h stays in the unit interval
    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8 + ITERS + 3] |-> (62'(r_h) <= ONE_Q))
        else $error("h out of range");

endmodule

// ===== tb/sv/haversine_distance_top_tb.sv =====
`timescale 1ns / 1ps

module haversine_distance_top_tb;

    localparam int LATENCY   = 105;
    localparam int N_RANDOM  = 900;
    localparam longint TURN  = 64'sd360 <<< 20;
    localparam longint LAT_LIM = 64'sd94371840;
    localparam longint LON_LIM = 64'sd188743680;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hvd_in_if  req_if ();
    hvd_out_if res_if ();

    haversine_distance_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    // expected distances, oldest first
    logic [hvd_pkg::DIST_W-1:0] dist_fifo [$];
    int  n_mismatch = 0;
    bit  rx_hold = 1'b0;

    initial begin
        req_if.valid = 1'b0;
        req_if.lat_a = '0;
        req_if.lon_a = '0;
        req_if.lat_b = '0;
        req_if.lon_b = '0;
        res_if.ready = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint asr_q(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        return (i < 10) ? longint'(hvd_pkg::ANGLE_TAB[i]) : (64'sd1 <<< (hvd_pkg::Q - i));
    endfunction

    // wrap into [-180, 180) degrees, truncating remainder like C
    function automatic longint wrap_deg(longint d);
        longint r;
        r = d % TURN;
        if (r < -(TURN / 2)) r += TURN;
        if (r >= TURN / 2) r -= TURN;
        return r;
    endfunction

    function automatic longint isqrt64(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // rotation cordic, returns sin and cos through outputs
    function automatic void rotate_q30(input longint z, output longint sn,
                                       output longint cs);
        longint x, y, dx, dy;
        x = longint'(hvd_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < hvd_pkg::CORDIC_ITERS; i++) begin
            dx = asr_q(y, i);
            dy = asr_q(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        sn = y;
        cs = x;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < hvd_pkg::CORDIC_ITERS; i++) begin
            dx = asr_q(y, i);
            dy = asr_q(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint half_sin_sq(longint d);
        longint r, sn, cs;
        longint unsigned mag;
        r = wrap_deg(d);
        mag = (r < 0) ? -r : r;
        rotate_q30(longint'((mag * longint'(hvd_pkg::PI_Q30)) / longint'(TURN)), sn, cs);
        return (sn * sn) >>> hvd_pkg::Q;
    endfunction

    function automatic longint lat_cosine(longint lat);
        longint r, sn, cs;
        longint unsigned a, ht;
        bit neg;
        ht = 64'd180 << 20;
        r = wrap_deg(lat);
        a = (r < 0) ? -r : r;
        neg = a > ht / 2;
        if (neg) a = ht - a;
        rotate_q30(longint'((a * longint'(hvd_pkg::PI_Q30)) / ht), sn, cs);
        return neg ? -cs : cs;
    endfunction

    function automatic logic [hvd_pkg::DIST_W-1:0] great_circle_m(longint la, longint oa,
                                                                 longint lb, longint ob);
        longint u2, v2, c, h, s, r, th;
        longint unsigned d;
        u2 = half_sin_sq(lb - la);
        v2 = half_sin_sq(ob - oa);
        c  = (lat_cosine(la) * lat_cosine(lb)) >>> hvd_pkg::Q;
        h  = u2 + ((c * v2) >>> hvd_pkg::Q);
        if (h < 0) h = 0;
        if (h > (64'sd1 <<< hvd_pkg::Q)) h = 64'sd1 <<< hvd_pkg::Q;
        s  = isqrt64(longint'(h) << hvd_pkg::Q);
        r  = isqrt64(((64'sd1 <<< hvd_pkg::Q) - h) << hvd_pkg::Q);
        th = vector_angle(s, r);
        if (th < 0) th = 0;
        if (th > longint'(hvd_pkg::HALF_PI_Q30)) th = hvd_pkg::HALF_PI_Q30;
        d = (longint'(th) * 64'd12742000) >> hvd_pkg::Q;
        return d[hvd_pkg::DIST_W-1:0];
    endfunction

    // ---------------- request driver ----------------
    // valid stays high after an accept; it drops only when a wait follows
    task automatic send_pair(input longint la, input longint oa, input longint lb,
                             input longint ob, input bit gaps);
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 15) : 0;
        if (wait_n != 0) begin
            req_if.valid <= 1'b0;
            repeat (wait_n) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.lat_a <= la[hvd_pkg::LAT_W-1:0];
        req_if.lon_a <= oa[hvd_pkg::LON_W-1:0];
        req_if.lat_b <= lb[hvd_pkg::LAT_W-1:0];
        req_if.lon_b <= ob[hvd_pkg::LON_W-1:0];
        dist_fifo.push_back(great_circle_m(la, oa, lb, ob));
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic longint rand_raw(int w);
        longint v;
        v = {$urandom, $urandom};
        v = v & ((64'sd1 <<< w) - 1);
        if (v[w-1]) v = v - (64'sd1 <<< w);
        return v;
    endfunction

    task automatic drain_all();
        req_if.valid <= 1'b0;
        while (dist_fifo.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- test tasks ----------------
    task automatic test_extremes();
        send_pair(0, 0, 0, 0, 1);
        send_pair(LAT_LIM, 0, -LAT_LIM, 0, 1);              // pole to pole
        send_pair(0, 0, 0, LON_LIM, 1);                     // antipodal on equator
        send_pair(0, -LON_LIM, 0, LON_LIM, 1);              // full turn of longitude
        send_pair(LAT_LIM, LON_LIM, LAT_LIM, -LON_LIM, 1);
        send_pair(-LAT_LIM, 123, -LAT_LIM, 456, 1);
        send_pair(1, 0, 0, 1, 1);                           // tiny steps
        send_pair(0, 0, 0, 1, 1);
        send_pair(45 <<< 20, 10 <<< 20, -45 <<< 20, -170 <<< 20, 1);
        send_pair(10 <<< 20, 179 <<< 20, 10 <<< 20, -179 <<< 20, 1);
    endtask

    // out-of-range angles: wrapping, latitude folding, negative cosine product
    task automatic test_wrap_and_fold();
        send_pair(-(64'sd1 <<< 27), -(64'sd1 <<< 28), (64'sd1 <<< 27) - 1,
                  (64'sd1 <<< 28) - 1, 1);
        send_pair((64'sd1 <<< 27) - 1, 0, 0, 0, 1);
        send_pair(100 <<< 20, 0, 0, 0, 1);
        send_pair(100 <<< 20, 0, -100 <<< 20, 90 <<< 20, 1);
        send_pair(120 <<< 20, 30 <<< 20, 20 <<< 20, 200 <<< 20, 1);
        send_pair(-(64'sd1 <<< 27), 0, -(64'sd1 <<< 27), 0, 1);
        send_pair(0, (64'sd1 <<< 28) - 1, 0, -(64'sd1 <<< 28), 1);
        send_pair(90 <<< 20, 0, 90 <<< 20, 180 <<< 20, 1);
    endtask

    task automatic test_random();
        longint la, oa, lb, ob;
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                la = rand_raw(hvd_pkg::LAT_W); oa = rand_raw(hvd_pkg::LON_W);
                lb = rand_raw(hvd_pkg::LAT_W); ob = rand_raw(hvd_pkg::LON_W);
            end else if ($urandom_range(0, 5) == 0) begin
                // nearby points, small distances
                la = rand_span(LAT_LIM); oa = rand_span(LON_LIM);
                lb = la + $urandom_range(0, 4095) - 2048;
                ob = oa + $urandom_range(0, 4095) - 2048;
                if (lb > LAT_LIM || lb < -LAT_LIM) lb = la;
            end else begin
                la = rand_span(LAT_LIM); oa = rand_span(LON_LIM);
                lb = rand_span(LAT_LIM); ob = rand_span(LON_LIM);
            end
            send_pair(la, oa, lb, ob, (n % 200) >= 40);
        end
    endtask

    // receiver holds off while requests keep coming, so the pipe backs up
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            for (int n = 0; n < 180; n++)
                send_pair(rand_span(LAT_LIM), rand_span(LON_LIM),
                          rand_span(LAT_LIM), rand_span(LON_LIM), 0);
        join
        drain_all();
    endtask

    // ---------------- result checker ----------------
    initial begin
        logic [hvd_pkg::DIST_W-1:0] want;
        int gap;
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 1) == 0) gap = 0;
            if (gap != 0 || rx_hold) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            if (dist_fifo.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result distance_m=%0d", res_if.distance_m);
            end else begin
                want = dist_fifo.pop_front();
                if (res_if.distance_m !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("distance_m mismatch: expected %0d, actual %0d",
                                 want, res_if.distance_m);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("haversine_distance_top_tb: done, errors");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_wrap_and_fold();
        drain_all();                       // sender pauses until all results are in
        test_backpressure();
        test_random();
        drain_all();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_mismatch == 0 && dist_fifo.size() == 0)
            $display("haversine_distance_top_tb: done, clean");
        else
            $display("haversine_distance_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hvd_pkg.sv
sv/hvd_if.sv
sv/hvd_cordic.sv
sv/haversine_distance_top.sv
tb/sv/haversine_distance_top_tb.sv
